@@ hw/rtl/qcps_pkg.sv @@
package qcps_pkg;

    localparam int NUM_W      = 32;
    localparam int POS_W      = 32;
    localparam int SPEED_OUT_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [NUM_W-1:0] NUMERATOR_RESET = NUM_W'(5744627);

    localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR = CFG_IDX_W'(1);

    typedef struct packed {
        logic channel_a;
        logic channel_b;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0]  position_count;
        logic [SPEED_OUT_W-1:0]   speed_q8;
        logic                     edge_seen;
    } t_out_item;

endpackage

@@ hw/rtl/quadrature_count_period_speed.sv @@
// Quadrature encoder position and speed. Each input transfer is one sample of
// channels A and B taken at the period tick; each one yields exactly one result
// transfer. A rising edge of A steps the signed position up when B is high and
// down when B is low (swapped by the invert register). Ticks between edges are
// counted with saturation, and on every edge the speed numerator register is
// divided by that count, truncated and saturated to the speed width. A sample
// without an edge goes to the done state, from which its result is loaded into
// the output register once the output slot is free. A sample with an edge
// first runs through the divider and only then reaches the done state:
// the bit-serial restoring divider yields one quotient bit per cycle over the
// 32-bit numerator, the saturated speed is registered, the output register is
// loaded and the block returns to idle to take the next sample.
// No new sample is taken until the current result has been loaded into the
// output register.
module quadrature_count_period_speed import qcps_pkg::*; #(
    parameter int COUNT_WIDTH  = 32,
    parameter int PERIOD_WIDTH = 32,
    parameter int SPEED_WIDTH  = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SAT_W = (NUM_W > SPEED_WIDTH) ? NUM_W : SPEED_WIDTH;
    localparam int POS_EXT_W = (COUNT_WIDTH > POS_W) ? COUNT_WIDTH : POS_W;
    localparam int SPD_EXT_W = (SPEED_WIDTH > SPEED_OUT_W) ? SPEED_WIDTH : SPEED_OUT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state                  r_state;
    logic                    r_invert;
    logic [NUM_W-1:0]        r_numerator;
    logic                    r_prev_a;
    logic [COUNT_WIDTH-1:0]  r_count;
    logic [PERIOD_WIDTH-1:0] r_ticks;
    logic [SPEED_WIDTH-1:0]  r_speed;
    logic                    r_edge;
    logic                    r_out_valid;
    t_out_item               r_out_data;

    logic                    in_fire;
    logic                    out_fire;
    logic                    cfg_fire;
    logic                    slot_free;
    logic                    load_out;
    logic                    edge_now;
    logic                    count_up;
    logic [PERIOD_WIDTH-1:0] n_ticks;
    logic [COUNT_WIDTH-1:0]  n_count;
    logic                    div_done;
    logic [NUM_W-1:0]        div_quot;
    logic [SAT_W-1:0]        quot_ext;
    logic [SAT_W-1:0]        smax_ext;
    logic [SPEED_WIDTH-1:0]  n_speed;
    logic [POS_EXT_W-1:0]    pos_ext;
    logic [SPD_EXT_W-1:0]    spd_ext;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign in_fire   = i_in_valid & o_in_ready;
    assign out_fire  = r_out_valid & i_out_ready;
    assign cfg_fire  = i_cfg_valid & o_cfg_ready;
    assign slot_free = ~r_out_valid | i_out_ready;
    assign load_out  = (r_state == ST_DONE) & slot_free;

    always_comb begin
        edge_now = ~r_prev_a & i_in_data.channel_a;
        count_up = i_in_data.channel_b ^ r_invert;
        n_ticks  = (&r_ticks) ? r_ticks : r_ticks + PERIOD_WIDTH'(1);
        n_count  = count_up ? r_count + COUNT_WIDTH'(1) : r_count - COUNT_WIDTH'(1);
        quot_ext = SAT_W'(div_quot);
        smax_ext = SAT_W'({SPEED_WIDTH{1'b1}});
        n_speed  = (quot_ext > smax_ext) ? {SPEED_WIDTH{1'b1}} : SPEED_WIDTH'(quot_ext);
        pos_ext  = POS_EXT_W'(r_count);
        spd_ext  = SPD_EXT_W'(r_speed);
    end

    qcps_div #(
        .DEN_W (PERIOD_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_fire & edge_now),
        .i_num   (r_numerator),
        .i_den   (n_ticks),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_invert    <= 1'b0;
            r_numerator <= NUMERATOR_RESET;
            r_prev_a    <= 1'b0;
            r_count     <= '0;
            r_ticks     <= '0;
            r_speed     <= '0;
            r_edge      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_fire) begin
                unique case (i_cfg_index)
                    CFG_INVERT:    r_invert    <= i_cfg_data[0];
                    CFG_NUMERATOR: r_numerator <= NUM_W'(i_cfg_data);
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_prev_a <= i_in_data.channel_a;
                        r_edge   <= edge_now;
                        if (edge_now) begin
                            r_count <= n_count;
                            r_ticks <= '0;
                            r_state <= ST_DIV;
                        end else begin
                            r_ticks <= n_ticks;
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_speed <= n_speed;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (slot_free) begin
                        r_out_data.position_count <= $signed(POS_W'(pos_ext));
                        r_out_data.speed_q8       <= SPEED_OUT_W'(spd_ext);
                        r_out_data.edge_seen      <= r_edge;
                        r_state                   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside of a division");

    a_no_edge_skips_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !edge_now) |=> (r_state == ST_DONE))
        else $error("sample without edge started a division");

    a_edge_clears_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_edge && r_state != ST_IDLE) |-> (r_ticks == '0))
        else $error("period count not restarted on edge");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |=> (!div_done || !o_in_ready || r_state == ST_DONE))
        else $error("sample taken while division running");
`endif

endmodule

@@ hw/rtl/qcps_div.sv @@
module qcps_div import qcps_pkg::*; #(
    parameter int DEN_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quot;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] n_rem;
    logic [NUM_W-1:0] n_quot;

    // one restoring step: shift in next numerator bit, trial subtract
    always_comb begin
        shifted = {r_rem, r_quot[NUM_W-1]};
        diff    = shifted - {1'b0, r_den};
        ge      = ~diff[DEN_W];
        n_rem   = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        n_quot  = {r_quot[NUM_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_den  <= i_den;
            r_quot <= i_num;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
